### hdl/pppm_pkg.sv
// Shared constants, types and register indexes of the pulse period pattern matcher.
package pppm_pkg;

	localparam int WIN_DEPTH    = 8;
	localparam int NUM_PATTERNS = 2;
	localparam int PAT_MAX      = 2;
	localparam int PAT_SLOTS    = 8;
	localparam int SLOTS_PER_WORD = 4;
	localparam int CMP_N        = (WIN_DEPTH < PAT_SLOTS) ? WIN_DEPTH : PAT_SLOTS;

	localparam int PERIOD_W = 16;
	localparam int TOL_W    = 8;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W    = 4;
	localparam int FILL_W   = $clog2(WIN_DEPTH + 1);
	localparam int FACTOR_W = TOL_W + 1;
	localparam int PROD_W   = PERIOD_W + FACTOR_W;

	localparam logic [FACTOR_W-1:0] TOL_ONE        = FACTOR_W'(256);
	localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(200);
	localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(65535);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PAT_A_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_A_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_B_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_B_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_A      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_B      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 3'd7;

	// Event operation codes.
	localparam logic OP_OVERFLOW = 1'b0;
	localparam logic OP_CAPTURE  = 1'b1;

	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [PERIOD_W:0]   bound_t;
	typedef logic [TOL_W-1:0]    tol_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [FILL_W-1:0]   fill_t;
	typedef logic [CFG_W-1:0]    cfg_word_t;

endpackage

### hdl/pppm_ifs.sv
// Valid/ready channel interfaces for timer events and match results.
interface pppm_evt_if import pppm_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    operation;
	period_t capture_count;

	modport source (output valid, output operation, output capture_count, input ready);
	modport sink   (input valid, input operation, input capture_count, output ready);
endinterface

interface pppm_res_if import pppm_pkg::*; ();
	logic valid;
	logic ready;
	logic hit;
	logic pattern_index;
	len_t matched_length;

	modport source (output valid, output hit, output pattern_index, output matched_length,
		input ready);
	modport sink   (input valid, input hit, input pattern_index, input matched_length,
		output ready);
endinterface

### hdl/pulse_period_pattern_matcher_unit.sv
// Top level of the pulse period pattern matcher: event window, pattern compare and result register.
//
// Usage. Timer events arrive on the evt channel, one request per event: an overflow tick
// or an edge capture with a 16-bit period count. Match results leave on the res channel,
// one request for each capture that fills the 8-deep period window: hit, pattern_index and
// matched_length, or a miss with all three fields zero. Other events give no result.
// Patterns, tolerances and the period limits are written through cfg_we/cfg_index/cfg_data
// while the block is idle; the tolerance bounds are recomputed into registers after a
// write, ahead of the next event's compare stage.
// An accepted event is registered in the input stage; its result is then registered in
// the result register and shown on res from there. Throughput: one event per cycle,
// except that an event that would give a result waits while the receiver stalls; the
// window compare and the window shift share the combinational logic of the input stage.
// Reset clears the window fill count, the overflow mark and both stages, and returns the
// configuration to its reset values (patterns zero, tolerances zero, limits 200 and 65535).
// When the receiver stalls, the result stays in the output register; further events that
// give no result still flow, and only an event that would give a second result waits in
// the input stage, which holds evt.ready low until the output register is free.
module pulse_period_pattern_matcher_unit import pppm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  cfg_word_t            cfg_data,
	pppm_evt_if.sink             evt,
	pppm_res_if.source           res
);

	// Configuration registers, kept as written.
	cfg_word_t pat_word_q [2*PAT_MAX];
	tol_t      tol_q [PAT_MAX];
	period_t   min_period_q;
	period_t   max_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2*PAT_MAX; i++) pat_word_q[i] <= '0;
			for (int i = 0; i < PAT_MAX; i++) tol_q[i] <= '0;
			min_period_q <= MIN_PERIOD_RST;
			max_period_q <= MAX_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_A_LOW:  pat_word_q[0] <= cfg_data;
				REG_PAT_A_HIGH: pat_word_q[1] <= cfg_data;
				REG_PAT_B_LOW:  pat_word_q[2] <= cfg_data;
				REG_PAT_B_HIGH: pat_word_q[3] <= cfg_data;
				REG_TOL_A:      tol_q[0] <= cfg_data[TOL_W-1:0];
				REG_TOL_B:      tol_q[1] <= cfg_data[TOL_W-1:0];
				REG_MIN_PERIOD: min_period_q <= cfg_data[PERIOD_W-1:0];
				REG_MAX_PERIOD: max_period_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived per-pattern data: inclusive period bounds for each slot and the pattern
	// length. Each bound is one 16x9 product, registered before the compare stage uses it.
	period_t lo_q  [NUM_PATTERNS][CMP_N];
	bound_t  hi_q  [NUM_PATTERNS][CMP_N];
	len_t    len_q [NUM_PATTERNS];

	period_t           slot_d   [NUM_PATTERNS][PAT_SLOTS];
	logic [PROD_W-1:0] lo_prod  [NUM_PATTERNS][CMP_N];
	logic [PROD_W-1:0] hi_prod  [NUM_PATTERNS][CMP_N];
	len_t              len_d    [NUM_PATTERNS];
	logic              zero_found;

	always_comb begin
		zero_found = 1'b0;
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			for (int k = 0; k < PAT_SLOTS; k++) begin
				slot_d[p][k] = pat_word_q[2*p + k/SLOTS_PER_WORD]
					[PERIOD_W*(k%SLOTS_PER_WORD) +: PERIOD_W];
			end
			for (int k = 0; k < CMP_N; k++) begin
				lo_prod[p][k] = {{FACTOR_W{1'b0}}, slot_d[p][k]}
					* {{PERIOD_W{1'b0}}, TOL_ONE - {1'b0, tol_q[p]}};
				hi_prod[p][k] = {{FACTOR_W{1'b0}}, slot_d[p][k]}
					* {{PERIOD_W{1'b0}}, TOL_ONE + {1'b0, tol_q[p]}};
			end
			// The length runs up to the first empty slot and never past the window.
			len_d[p]   = LEN_W'(CMP_N);
			zero_found = 1'b0;
			for (int k = 0; k < CMP_N; k++) begin
				if (!zero_found && slot_d[p][k] == '0) begin
					len_d[p]   = LEN_W'(k);
					zero_found = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PATTERNS; p++) len_q[p] <= '0;
		end else begin
			for (int p = 0; p < NUM_PATTERNS; p++) len_q[p] <= len_d[p];
		end
	end

	always_ff @(posedge clk) begin
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			for (int k = 0; k < CMP_N; k++) begin
				lo_q[p][k] <= lo_prod[p][k][PROD_W-2:TOL_W];
				hi_q[p][k] <= hi_prod[p][k][PROD_W-1:TOL_W];
			end
		end
	end

	// Input stage.
	logic    valid_s1;
	logic    op_s1;
	period_t count_s1;

	// Window state.
	period_t win_q [WIN_DEPTH];
	fill_t   fill_q;
	logic    overflow_q;

	// Result register.
	logic out_valid_q;
	logic hit_q;
	logic pat_idx_q;
	len_t match_len_q;

	logic    kept;
	logic    full_now;
	logic    advance_ok;
	logic    fire;
	period_t win_ext [WIN_DEPTH];
	logic    slot_ok [NUM_PATTERNS][CMP_N];
	logic    pat_hit [NUM_PATTERNS];
	logic    any_hit;
	logic    sel_idx;
	len_t    sel_len;
	len_t    drop_n;
	period_t win_shift [WIN_DEPTH];

	always_comb begin
		kept = valid_s1 && op_s1 == OP_CAPTURE && !overflow_q
			&& count_s1 >= min_period_q && count_s1 < max_period_q;
		full_now = kept && fill_q == FILL_W'(WIN_DEPTH - 1);

		// The window as it stands once this capture is appended.
		for (int k = 0; k < WIN_DEPTH; k++) begin
			win_ext[k] = (fill_t'(k) == fill_q) ? count_s1 : win_q[k];
		end

		// A window period of zero never matches.
		for (int p = 0; p < NUM_PATTERNS; p++) begin
			pat_hit[p] = len_q[p] != '0;
			for (int k = 0; k < CMP_N; k++) begin
				slot_ok[p][k] = win_ext[k] != '0 && win_ext[k] >= lo_q[p][k]
					&& {1'b0, win_ext[k]} <= hi_q[p][k];
				if (len_t'(k) < len_q[p] && !slot_ok[p][k]) pat_hit[p] = 1'b0;
			end
		end

		// The lowest-numbered pattern that hits wins.
		any_hit = 1'b0;
		sel_idx = 1'b0;
		sel_len = '0;
		for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
			if (pat_hit[p]) begin
				any_hit = 1'b1;
				sel_idx = 1'(p);
				sel_len = len_q[p];
			end
		end
		drop_n = any_hit ? sel_len : len_t'(1);

		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_shift[i] = win_ext[i];
			for (int j = 0; j < WIN_DEPTH; j++) begin
				if ({1'b0, drop_n} + (LEN_W+1)'(i) == (LEN_W+1)'(j)) win_shift[i] = win_ext[j];
			end
		end

		advance_ok = !full_now || !out_valid_q || res.ready;
		fire       = valid_s1 && advance_ok;
	end

	assign evt.ready = !valid_s1 || advance_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fill_q      <= '0;
			overflow_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt.ready) valid_s1 <= evt.valid;
			if (fire) begin
				overflow_q <= op_s1 == OP_OVERFLOW;
				if (full_now) fill_q <= fill_t'(WIN_DEPTH) - fill_t'(drop_n);
				else if (kept) fill_q <= fill_q + fill_t'(1);
			end
			if (fire && full_now) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			op_s1    <= evt.operation;
			count_s1 <= evt.capture_count;
		end
		if (fire && kept) begin
			for (int k = 0; k < WIN_DEPTH; k++) begin
				win_q[k] <= full_now ? win_shift[k] : win_ext[k];
			end
		end
		if (fire && full_now) begin
			hit_q       <= any_hit;
			pat_idx_q   <= any_hit ? sel_idx : 1'b0;
			match_len_q <= any_hit ? sel_len : '0;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.hit            = hit_q;
	assign res.pattern_index  = pat_idx_q;
	assign res.matched_length = match_len_q;

`ifndef NO_ASSERTIONS
	// The window never rests full: every full window loses at least one period.
	a_fill_below_depth: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN_DEPTH - 1))
		else $error("window fill reached the depth");

	// A shown miss carries zero index and zero length; a hit carries a length.
	a_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (hit_q ? match_len_q != '0 : (match_len_q == '0 && !pat_idx_q)))
		else $error("result fields disagree with hit");

	// A filling capture always produces a result in the next cycle.
	a_full_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && full_now |=> out_valid_q)
		else $error("full window gave no result");

	// A stalled result must not be overwritten by the next filling capture.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res.ready |-> !(fire && full_now))
		else $error("pending result overwritten");

	// An overflow tick leaves the mark set for the next capture.
	a_overflow_mark: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_s1 == OP_OVERFLOW |=> overflow_q)
		else $error("overflow mark lost");
`endif

endmodule
